[rtl/mele_pkg.sv]
// ----------------------------------------------------------------------------
// mele_pkg
// Shared types, codes and text tables for the modem escape and line editor.
// ----------------------------------------------------------------------------
package mele_pkg;

  // line buffer limits
  localparam int LINE_MAX_DEF = 64;
  localparam int LEN_W        = 7;   // holds any line length up to 64
  localparam int IDX_W        = 7;   // back end word index
  localparam int QUEUE_DEPTH  = 2;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_GUARD  = 2'd0;
  localparam logic [1:0] REG_ESCAPE = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  // register reset values
  localparam logic [15:0] GUARD_RST  = 16'd1000;
  localparam logic [7:0]  ESCAPE_RST = 8'd43;
  localparam logic [2:0]  COUNT_RST  = 3'd3;

  // event kinds
  localparam logic [1:0] EV_HOST = 2'd0;
  localparam logic [1:0] EV_NET  = 2'd1;
  localparam logic [1:0] EV_LINK = 2'd2;
  localparam logic [1:0] EV_LOST = 2'd3;

  // result channels
  localparam logic [1:0] CH_HOST = 2'd0;
  localparam logic [1:0] CH_NET  = 2'd1;
  localparam logic [1:0] CH_LINE = 2'd2;

  // characters
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_DEL   = 8'd127;

  // work handed from front end to back end
  typedef enum logic [2:0] {
    JOB_BYTE,
    JOB_BS,
    JOB_OK,
    JOB_NC,
    JOB_LINE
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [1:0]       chan;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } job_t;

  typedef struct packed {
    logic [15:0] guard_ms;
    logic [7:0]  escape_char;
    logic [2:0]  escape_count;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TEXT,
    BK_LREAD,
    BK_LEMIT
  } bk_state_t;

  // CR LF "OK" CR LF
  function automatic logic [7:0] ok_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = CHAR_CR;
      4'd1:    c = CHAR_LF;
      4'd2:    c = 8'h4F;
      4'd3:    c = 8'h4B;
      4'd4:    c = CHAR_CR;
      4'd5:    c = CHAR_LF;
      default: c = CHAR_LF;
    endcase
    return c;
  endfunction

  // CR LF "NO CARRIER" CR LF
  function automatic logic [7:0] nc_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = CHAR_CR;
      4'd1:    c = CHAR_LF;
      4'd2:    c = 8'h4E;
      4'd3:    c = 8'h4F;
      4'd4:    c = CHAR_SPACE;
      4'd5:    c = 8'h43;
      4'd6:    c = 8'h41;
      4'd7:    c = 8'h52;
      4'd8:    c = 8'h52;
      4'd9:    c = 8'h49;
      4'd10:   c = 8'h45;
      4'd11:   c = 8'h52;
      4'd12:   c = CHAR_CR;
      4'd13:   c = CHAR_LF;
      default: c = CHAR_LF;
    endcase
    return c;
  endfunction

  // words produced by a fixed-length job
  function automatic logic [IDX_W-1:0] text_len(input job_kind_t k);
    logic [IDX_W-1:0] n;
    case (k)
      JOB_BYTE: n = IDX_W'(1);
      JOB_BS:   n = IDX_W'(3);
      JOB_OK:   n = IDX_W'(6);
      JOB_NC:   n = IDX_W'(14);
      default:  n = IDX_W'(1);
    endcase
    return n;
  endfunction

endpackage

[rtl/mele_ram.sv]
// ----------------------------------------------------------------------------
// mele_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mele_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mele_fifo.sv]
// ----------------------------------------------------------------------------
// mele_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mele_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mele_pkg::job_t  wdata,
  output logic            full,
  input  logic            pop,
  output mele_pkg::job_t  rdata,
  output logic            empty
);

  localparam int PW = (mele_pkg::QUEUE_DEPTH > 1) ? $clog2(mele_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(mele_pkg::QUEUE_DEPTH + 1);

  mele_pkg::job_t entry [mele_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(mele_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(mele_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(mele_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/mele_front.sv]
// ----------------------------------------------------------------------------
// mele_front
// Accepts events, keeps mode, escape and line state, and queues output jobs.
// ----------------------------------------------------------------------------
module mele_front #(
  parameter int LINE_MAX = mele_pkg::LINE_MAX_DEF,
  localparam int LW = $clog2(LINE_MAX + 1),
  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      mode,
  input  logic [7:0]      data_byte,
  input  logic [31:0]     now_ms,
  input  mele_pkg::cfg_t  cfg,
  output logic            push,
  output mele_pkg::job_t  job,
  input  logic            fifo_full,
  input  logic            line_done,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [7:0]      wr_data
);

  logic          in_data_mode, in_data_mode_next;
  logic          link_up, link_up_next;
  logic [2:0]    escape_seen, escape_seen_next;
  logic [31:0]   last_escape_time, last_escape_time_next;
  logic [LW-1:0] line_length, line_length_next;
  logic          line_pend, line_pend_next;

  logic          accept;
  logic [2:0]    need;
  logic [31:0]   gap;
  logic [2:0]    seen_inc;

  // hold off while the queue is full or a line is still being read out
  assign in_stall = fifo_full || line_pend;
  assign accept   = in_valid && !in_stall;

  assign need     = (cfg.escape_count == 3'd0) ? 3'd1 : cfg.escape_count;
  assign gap      = now_ms - last_escape_time;
  assign seen_inc = ((gap > {16'd0, cfg.guard_ms}) ? 3'd0 : escape_seen) + 3'd1;

  assign wr_addr = line_length[AW-1:0];
  assign wr_data = data_byte;

  // event handling
  always_comb begin
    in_data_mode_next     = in_data_mode;
    link_up_next          = link_up;
    escape_seen_next      = escape_seen;
    last_escape_time_next = last_escape_time;
    line_length_next      = line_length;
    line_pend_next        = line_pend && !line_done;
    push                  = 1'b0;
    wr_en                 = 1'b0;
    job.kind              = mele_pkg::JOB_BYTE;
    job.chan              = mele_pkg::CH_HOST;
    job.data              = data_byte;
    job.len               = mele_pkg::LEN_W'(line_length);

    if (accept) begin
      case (mode)
        mele_pkg::EV_HOST: begin
          if (in_data_mode) begin
            if (data_byte == cfg.escape_char) begin
              last_escape_time_next = now_ms;
              if (seen_inc == need) begin
                in_data_mode_next = 1'b0;
                escape_seen_next  = 3'd0;
                push              = 1'b1;
                job.kind          = mele_pkg::JOB_OK;
              end else begin
                escape_seen_next = seen_inc;
              end
            end else begin
              escape_seen_next = 3'd0;
              if (link_up) begin
                push     = 1'b1;
                job.chan = mele_pkg::CH_NET;
              end
            end
          end else if (data_byte == mele_pkg::CHAR_CR || data_byte == mele_pkg::CHAR_LF) begin
            if (line_length != '0) begin
              push             = 1'b1;
              job.kind         = mele_pkg::JOB_LINE;
              line_length_next = '0;
              line_pend_next   = 1'b1;
            end
          end else if (data_byte == mele_pkg::CHAR_BS || data_byte == mele_pkg::CHAR_DEL) begin
            if (line_length != '0) begin
              push             = 1'b1;
              job.kind         = mele_pkg::JOB_BS;
              line_length_next = line_length - LW'(1);
            end
          end else if (line_length < LW'(LINE_MAX)) begin
            wr_en            = 1'b1;
            push             = 1'b1;
            line_length_next = line_length + LW'(1);
          end
        end
        mele_pkg::EV_NET: begin
          if (in_data_mode && link_up) begin
            push = 1'b1;
          end
        end
        mele_pkg::EV_LINK: begin
          link_up_next      = 1'b1;
          in_data_mode_next = 1'b1;
          escape_seen_next  = 3'd0;
        end
        default: begin
          link_up_next = 1'b0;
          if (in_data_mode) begin
            in_data_mode_next = 1'b0;
            push              = 1'b1;
            job.kind          = mele_pkg::JOB_NC;
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_data_mode     <= 1'b0;
      link_up          <= 1'b0;
      escape_seen      <= 3'd0;
      last_escape_time <= 32'd0;
      line_length      <= '0;
      line_pend        <= 1'b0;
    end else begin
      in_data_mode     <= in_data_mode_next;
      link_up          <= link_up_next;
      escape_seen      <= escape_seen_next;
      last_escape_time <= last_escape_time_next;
      line_length      <= line_length_next;
      line_pend        <= line_pend_next;
    end
  end

endmodule

[rtl/mele_back.sv]
// ----------------------------------------------------------------------------
// mele_back
// Carries out queued jobs, one output word at a time, into an output register.
// ----------------------------------------------------------------------------
module mele_back #(
  parameter int LINE_MAX = mele_pkg::LINE_MAX_DEF,
  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fifo_empty,
  output logic            pop,
  input  mele_pkg::job_t  job,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr,
  input  logic [7:0]      rd_data,
  output logic            line_done,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      channel,
  output logic [7:0]      out_byte,
  output logic            last
);

  localparam int IW = mele_pkg::IDX_W;

  mele_pkg::bk_state_t state, state_next;
  mele_pkg::job_t      cur, cur_next;
  logic [IW-1:0]       idx, idx_next;

  logic                can_load;
  logic                load;
  logic [1:0]          ld_chan;
  logic [7:0]          ld_byte;
  logic                ld_last;
  logic [7:0]          text_byte;

  assign can_load = !out_valid || !out_stall;
  assign rd_addr  = idx[AW-1:0];

  // byte of a fixed-length job
  always_comb begin
    case (cur.kind)
      mele_pkg::JOB_BS:  text_byte = (idx == IW'(1)) ? mele_pkg::CHAR_SPACE : cur.data;
      mele_pkg::JOB_OK:  text_byte = mele_pkg::ok_char(idx[3:0]);
      mele_pkg::JOB_NC:  text_byte = mele_pkg::nc_char(idx[3:0]);
      default:           text_byte = cur.data;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    cur_next   = cur;
    idx_next   = idx;
    pop        = 1'b0;
    rd_en      = 1'b0;
    line_done  = 1'b0;
    load       = 1'b0;
    ld_chan    = mele_pkg::CH_HOST;
    ld_byte    = text_byte;
    ld_last    = 1'b0;

    case (state)
      mele_pkg::BK_IDLE: begin
        if (!fifo_empty) begin
          pop        = 1'b1;
          cur_next   = job;
          idx_next   = '0;
          state_next = (job.kind == mele_pkg::JOB_LINE) ? mele_pkg::BK_LREAD
                                                        : mele_pkg::BK_TEXT;
        end
      end
      mele_pkg::BK_TEXT: begin
        if (can_load) begin
          load    = 1'b1;
          ld_chan = (cur.kind == mele_pkg::JOB_BYTE) ? cur.chan : mele_pkg::CH_HOST;
          ld_last = (idx == mele_pkg::text_len(cur.kind) - IW'(1));
          if (ld_last) begin
            state_next = mele_pkg::BK_IDLE;
          end else begin
            idx_next = idx + IW'(1);
          end
        end
      end
      mele_pkg::BK_LREAD: begin
        rd_en      = 1'b1;
        state_next = mele_pkg::BK_LEMIT;
      end
      mele_pkg::BK_LEMIT: begin
        if (can_load) begin
          load    = 1'b1;
          ld_chan = mele_pkg::CH_LINE;
          ld_byte = rd_data;
          ld_last = (idx == IW'(cur.len) - IW'(1));
          if (ld_last) begin
            state_next = mele_pkg::BK_IDLE;
            line_done  = 1'b1;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = mele_pkg::BK_LREAD;
          end
        end
      end
      default: begin
        state_next = mele_pkg::BK_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mele_pkg::BK_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      channel  <= ld_chan;
      out_byte <= ld_byte;
      last     <= ld_last;
    end
  end

endmodule

[rtl/modem_escape_and_line_editor.sv]
// ----------------------------------------------------------------------------
// modem_escape_and_line_editor
// Modem escape detector and command line editor: a front end tracks mode,
// escape count and the line buffer, a back end streams the reply words.
// ----------------------------------------------------------------------------
//
//   port group   direction   handshake           word
//   events       in          in_valid/in_stall   mode, data_byte, now_ms
//   results      out         out_valid/out_stall channel, out_byte, last
//   registers    in/out      apb                 guard_ms, escape_char, escape_count
//
// Events stall while the two-entry job queue is full or a released line is
// still being read; events with no result leave nothing queued. Replies leave
// one word a cycle while the output is not stalled (single byte, echo triple,
// OK, NO CARRIER); each byte of a released line is first read from the line
// store's registered read port, then emitted. A single-word event passes the
// job queue, the back end's job register and then the output register.
// Reset is synchronous and clears control state; the line store is not cleared.
// ----------------------------------------------------------------------------
module modem_escape_and_line_editor #(
  parameter int LINE_MAX = mele_pkg::LINE_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [7:0]                    data_byte,
  input  logic [31:0]                   now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    channel,
  output logic [7:0]                    out_byte,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mele_pkg::ADDR_W-1:0]   paddr,
  input  logic [mele_pkg::DATA_W-1:0]   pwdata,
  output logic [mele_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  mele_pkg::cfg_t cfg;
  logic           cfg_wr;

  mele_pkg::job_t push_job;
  mele_pkg::job_t pop_job;
  logic           push;
  logic           pop;
  logic           fifo_full;
  logic           fifo_empty;
  logic           line_done;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.guard_ms     <= mele_pkg::GUARD_RST;
      cfg.escape_char  <= mele_pkg::ESCAPE_RST;
      cfg.escape_count <= mele_pkg::COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mele_pkg::REG_GUARD:  cfg.guard_ms     <= pwdata[15:0];
        mele_pkg::REG_ESCAPE: cfg.escape_char  <= pwdata[7:0];
        mele_pkg::REG_COUNT:  cfg.escape_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      mele_pkg::REG_GUARD:  prdata = {16'd0, cfg.guard_ms};
      mele_pkg::REG_ESCAPE: prdata = {24'd0, cfg.escape_char};
      mele_pkg::REG_COUNT:  prdata = {29'd0, cfg.escape_count};
      default:              prdata = '0;
    endcase
  end

  mele_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .data_byte (data_byte),
    .now_ms    (now_ms),
    .cfg       (cfg),
    .push      (push),
    .job       (push_job),
    .fifo_full (fifo_full),
    .line_done (line_done),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  mele_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .full  (fifo_full),
    .pop   (pop),
    .rdata (pop_job),
    .empty (fifo_empty)
  );

  mele_ram #(
    .WIDTH (8),
    .DEPTH (LINE_MAX)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mele_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .job        (pop_job),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .line_done  (line_done),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .channel    (channel),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule

[rtl/mele_checker.sv]
// ----------------------------------------------------------------------------
// mele_checker
// Port-level checks on the modem escape and line editor, bound to the top.
// ----------------------------------------------------------------------------
module mele_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  mode,
  input logic [7:0]                  data_byte,
  input logic [31:0]                 now_ms,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  channel,
  input logic [7:0]                  out_byte,
  input logic                        last,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [mele_pkg::ADDR_W-1:0] paddr,
  input logic [mele_pkg::DATA_W-1:0] pwdata,
  input logic [mele_pkg::DATA_W-1:0] prdata,
  input logic                        pready
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(channel) && $stable(out_byte)
                               && $stable(last))
    else $error("stalled output word changed");

  // nothing leaves straight after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // only three channels exist
  a_chan_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> channel != 2'd3)
    else $error("unknown channel code");

  // a byte to the network is always the only result of its event
  a_net_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && channel == mele_pkg::CH_NET |-> last)
    else $error("network byte not marked last");

  // the input side stays held while a line is part way out
  a_line_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && channel == mele_pkg::CH_LINE && !last |-> in_stall)
    else $error("input taken in the middle of a line release");

endmodule

bind modem_escape_and_line_editor mele_checker u_mele_checker (.*);

[tb/modem_escape_and_line_editor_tb.sv]
// ----------------------------------------------------------------------------
// modem_escape_and_line_editor_tb
// Drives modem events (host byte, network byte, link up, carrier lost) through
// the valid/stall input and checks every result word against a behavioural
// predictor of the escape detector and line editor. The registers are set
// through the APB port between phases. A short directed run comes first, then
// random sessions: connect, traffic, escape run or carrier loss, a typed
// command line, with some noise between sessions.
// ----------------------------------------------------------------------------
module modem_escape_and_line_editor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 20;

  localparam logic [47:0] OK_REPLY = {mele_pkg::CHAR_CR, mele_pkg::CHAR_LF, "OK",
                                      mele_pkg::CHAR_CR, mele_pkg::CHAR_LF};
  localparam logic [111:0] NC_REPLY = {mele_pkg::CHAR_CR, mele_pkg::CHAR_LF, "NO CARRIER",
                                       mele_pkg::CHAR_CR, mele_pkg::CHAR_LF};

  typedef struct packed {
    logic [1:0] chan;
    logic [7:0] data;
    logic       lst;
  } modem_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data;
    logic [31:0] stamp;
    logic        sync;
  } modem_event_t;

  // dut signals
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = mele_pkg::EV_HOST;
  logic [7:0]  data_byte = 8'd0;
  logic [31:0] now_ms = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  channel;
  logic [7:0]  out_byte;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [mele_pkg::ADDR_W-1:0] paddr = '0;
  logic [mele_pkg::DATA_W-1:0] pwdata = '0;
  logic [mele_pkg::DATA_W-1:0] prdata;
  logic        pready;

  // register copies used by the predictor and the generator
  logic [15:0] cfg_guard = mele_pkg::GUARD_RST;
  logic [7:0]  cfg_escape = mele_pkg::ESCAPE_RST;
  logic [2:0]  cfg_count = mele_pkg::COUNT_RST;

  // predicted modem state
  logic        mdl_data_mode = 1'b0;
  logic        mdl_link = 1'b0;
  logic [2:0]  mdl_seen = 3'd0;
  logic [31:0] mdl_last_esc = 32'd0;
  logic [7:0]  mdl_line [mele_pkg::LINE_MAX_DEF];
  int          mdl_len = 0;

  modem_word_t  awaited_words[$];
  modem_event_t pending_events[$];
  modem_event_t next_ev;

  // generator tracking of the escape run
  logic [2:0]  gen_seen = 3'd0;
  logic [31:0] gen_last_esc = 32'd0;
  logic [31:0] t_now = 32'd0;
  int          queued_count = 0;

  int          send_idle_pct = 13;
  int          recv_idle_pct = 67;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  modem_escape_and_line_editor uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .data_byte(data_byte), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .channel(channel), .out_byte(out_byte), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor
  task automatic push_word(input logic [1:0] chan, input logic [7:0] data);
    modem_word_t w;
    w.chan = chan;
    w.data = data;
    w.lst = 1'b0;
    awaited_words.push_back(w);
  endtask

  task automatic push_text(input logic [111:0] text, input int count);
    for (int i = count - 1; i >= 0; i--) push_word(mele_pkg::CH_HOST, text[i*8 +: 8]);
  endtask

  task automatic modem_step(input logic [1:0] m, input logic [7:0] b,
                            input logic [31:0] stamp);
    int          base;
    logic [2:0]  need;
    modem_word_t w;
    base = awaited_words.size();
    case (m)
      mele_pkg::EV_HOST: begin
        if (mdl_data_mode) begin
          if (b == cfg_escape) begin
            need = (cfg_count == 3'd0) ? 3'd1 : cfg_count;
            if ((stamp - mdl_last_esc) > {16'd0, cfg_guard}) mdl_seen = 3'd0;
            mdl_seen = mdl_seen + 3'd1;
            mdl_last_esc = stamp;
            if (mdl_seen == need) begin
              mdl_data_mode = 1'b0;
              mdl_seen = 3'd0;
              push_text(112'(OK_REPLY), 6);
            end
          end else begin
            mdl_seen = 3'd0;
            if (mdl_link) push_word(mele_pkg::CH_NET, b);
          end
        end else if (b == mele_pkg::CHAR_CR || b == mele_pkg::CHAR_LF) begin
          for (int i = 0; i < mdl_len; i++) push_word(mele_pkg::CH_LINE, mdl_line[i]);
          mdl_len = 0;
        end else if (b == mele_pkg::CHAR_BS || b == mele_pkg::CHAR_DEL) begin
          if (mdl_len > 0) begin
            mdl_len--;
            push_word(mele_pkg::CH_HOST, b);
            push_word(mele_pkg::CH_HOST, mele_pkg::CHAR_SPACE);
            push_word(mele_pkg::CH_HOST, b);
          end
        end else if (mdl_len < mele_pkg::LINE_MAX_DEF) begin
          mdl_line[mdl_len] = b;
          mdl_len++;
          push_word(mele_pkg::CH_HOST, b);
        end
      end
      mele_pkg::EV_NET: begin
        if (mdl_data_mode && mdl_link) push_word(mele_pkg::CH_HOST, b);
      end
      mele_pkg::EV_LINK: begin
        mdl_link = 1'b1;
        mdl_data_mode = 1'b1;
        mdl_seen = 3'd0;
      end
      default: begin
        mdl_link = 1'b0;
        if (mdl_data_mode) begin
          mdl_data_mode = 1'b0;
          push_text(NC_REPLY, 14);
        end
      end
    endcase
    // mark the final word of this event
    if (awaited_words.size() > base) begin
      w = awaited_words.pop_back();
      w.lst = 1'b1;
      awaited_words.push_back(w);
    end
  endtask

  // driver: offers queued events, predicts each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) modem_step(mode, data_byte, now_ms);
      if (!in_valid || !in_stall) begin
        if (pending_events.size() != 0 &&
            !(pending_events[0].sync && awaited_words.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          next_ev = pending_events.pop_front();
          in_valid <= 1'b1;
          mode <= next_ev.mode;
          data_byte <= next_ev.data;
          now_ms <= next_ev.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result words and drives the output stall
  always @(posedge clk) begin
    modem_word_t w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: word with none expected: got ch %0d byte %02h last %0b",
                   $time, channel, out_byte, last);
          mismatches++;
        end else begin
          w = awaited_words.pop_front();
          if (channel !== w.chan || out_byte !== w.data || last !== w.lst) begin
            $display("%0t: expected ch %0d byte %02h last %0b, got ch %0d byte %02h last %0b",
                     $time, w.chan, w.data, w.lst, channel, out_byte, last);
            mismatches++;
          end
        end
      end
      // one long hold-off, otherwise random stalls
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modem_escape_and_line_editor test failed");
      $finish;
    end
  end

  // stimulus helpers
  task automatic add_event(input logic [1:0] m, input logic [7:0] b,
                           input logic [31:0] stamp);
    modem_event_t e;
    e.mode = m;
    e.data = b;
    e.stamp = stamp;
    e.sync = ($urandom_range(39) == 0);
    pending_events.push_back(e);
    queued_count++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= mele_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mele_pkg::REG_GUARD:  cfg_guard = value[15:0];
      mele_pkg::REG_ESCAPE: cfg_escape = value[7:0];
      default:              cfg_count = value[2:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_valid || awaited_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == cfg_escape) b = b ^ 8'h01;
    return b;
  endfunction

  // escape characters until the count is reached, with gaps around the guard
  task automatic escape_run();
    logic [2:0]  need;
    logic [31:0] gap;
    logic        done;
    need = (cfg_count == 3'd0) ? 3'd1 : cfg_count;
    done = 1'b0;
    while (!done) begin
      case ($urandom_range(15))
        0:       gap = 32'(cfg_guard) + 32'd1 + 32'($urandom_range(50));
        1:       gap = $urandom;
        2:       gap = 32'(cfg_guard);
        3:       gap = 32'd0;
        default: gap = 32'($urandom_range(cfg_guard));
      endcase
      if (gap > 32'(cfg_guard)) gen_seen = 3'd0;
      gen_seen = gen_seen + 3'd1;
      gen_last_esc = gen_last_esc + gap;
      t_now = gen_last_esc;
      add_event(mele_pkg::EV_HOST, cfg_escape, t_now);
      if (gen_seen == need) begin
        done = 1'b1;
      end else if ($urandom_range(19) == 0) begin
        t_now += $urandom_range(100);
        add_event(mele_pkg::EV_HOST, plain_byte(), t_now);
        gen_seen = 3'd0;
      end
    end
  endtask

  // a typed command line with editing, then CR or LF
  task automatic type_line();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 10);
    repeat (n) begin
      t_now += $urandom_range(400);
      case ($urandom_range(11))
        0:       add_event(mele_pkg::EV_HOST,
                           $urandom_range(1) ? mele_pkg::CHAR_BS : mele_pkg::CHAR_DEL, t_now);
        1:       add_event(mele_pkg::EV_NET, 8'($urandom), t_now);
        2:       add_event(mele_pkg::EV_LOST, 8'($urandom), t_now);
        default: add_event(mele_pkg::EV_HOST, 8'($urandom), t_now);
      endcase
    end
    add_event(mele_pkg::EV_HOST,
              $urandom_range(1) ? mele_pkg::CHAR_CR : mele_pkg::CHAR_LF, t_now);
    if ($urandom_range(4) == 0) add_event(mele_pkg::EV_HOST, mele_pkg::CHAR_CR, t_now);
  endtask

  task automatic run_session();
    t_now += $urandom_range(5000);
    add_event(mele_pkg::EV_LINK, 8'($urandom), t_now);
    gen_seen = 3'd0;
    // data mode traffic
    repeat ($urandom_range(6)) begin
      t_now += $urandom_range(3000);
      if ($urandom_range(1)) add_event(mele_pkg::EV_HOST, plain_byte(), t_now);
      else add_event(mele_pkg::EV_NET, 8'($urandom), t_now);
    end
    if ($urandom_range(7) == 0) add_event(mele_pkg::EV_LOST, 8'($urandom), t_now);
    else escape_run();
    type_line();
    // noise between sessions
    if ($urandom_range(5) == 0) begin
      repeat ($urandom_range(1, 4)) add_event(2'($urandom), 8'($urandom), $urandom);
    end
  endtask

  // main sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: editing, empty cases, data mode, wrapped escape run, guard edges
    add_event(mele_pkg::EV_HOST, "A", 32'd10);
    add_event(mele_pkg::EV_HOST, mele_pkg::CHAR_BS, 32'd20);
    add_event(mele_pkg::EV_HOST, mele_pkg::CHAR_DEL, 32'd30);
    add_event(mele_pkg::EV_HOST, mele_pkg::CHAR_CR, 32'd40);
    add_event(mele_pkg::EV_NET, 8'h55, 32'd50);
    add_event(mele_pkg::EV_HOST, "h", 32'd60);
    add_event(mele_pkg::EV_HOST, "i", 32'd70);
    add_event(mele_pkg::EV_HOST, mele_pkg::CHAR_DEL, 32'd80);
    add_event(mele_pkg::EV_HOST, "i", 32'd90);
    add_event(mele_pkg::EV_HOST, mele_pkg::CHAR_LF, 32'd100);
    add_event(mele_pkg::EV_LOST, 8'h00, 32'd110);
    add_event(mele_pkg::EV_LINK, 8'hFF, 32'd120);
    add_event(mele_pkg::EV_HOST, 8'h00, 32'd130);
    add_event(mele_pkg::EV_HOST, 8'hFF, 32'd140);
    add_event(mele_pkg::EV_NET, 8'h00, 32'd150);
    add_event(mele_pkg::EV_NET, 8'hFF, 32'd160);
    add_event(mele_pkg::EV_HOST, mele_pkg::ESCAPE_RST, 32'hFFFF_FFF0);
    add_event(mele_pkg::EV_HOST, mele_pkg::ESCAPE_RST, 32'h0000_0010);
    add_event(mele_pkg::EV_HOST, mele_pkg::ESCAPE_RST, 32'h0000_03F8);
    add_event(mele_pkg::EV_LINK, 8'h00, 32'd1500);
    add_event(mele_pkg::EV_HOST, mele_pkg::ESCAPE_RST, 32'd2000);
    add_event(mele_pkg::EV_HOST, "x", 32'd2050);
    add_event(mele_pkg::EV_HOST, mele_pkg::ESCAPE_RST, 32'd2100);
    add_event(mele_pkg::EV_HOST, mele_pkg::ESCAPE_RST, 32'd3101);
    add_event(mele_pkg::EV_LOST, 8'hFF, 32'hFFFF_FFFF);
    gen_last_esc = 32'd3101;
    wait_idle();

    // sender idles little, receiver a lot, with one long hold-off
    write_reg(mele_pkg::REG_GUARD, 32'd65535);
    write_reg(mele_pkg::REG_ESCAPE, 32'd0);
    write_reg(mele_pkg::REG_COUNT, 32'd7);
    t_now = $urandom;
    hold_req = 1'b1;
    while (queued_count < 100) run_session();
    wait_idle();

    // roles swapped
    send_idle_pct = 67;
    recv_idle_pct = 13;
    write_reg(mele_pkg::REG_GUARD, 32'd0);
    write_reg(mele_pkg::REG_ESCAPE, 32'd255);
    write_reg(mele_pkg::REG_COUNT, 32'd1);
    while (queued_count < 150) run_session();
    wait_idle();

    write_reg(mele_pkg::REG_GUARD, 32'd5);
    write_reg(mele_pkg::REG_ESCAPE, 32'(mele_pkg::ESCAPE_RST));
    write_reg(mele_pkg::REG_COUNT, 32'd0);
    while (queued_count < 175) run_session();
    wait_idle();

    // no idling, CR as the escape character
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(mele_pkg::REG_GUARD, 32'd1000);
    write_reg(mele_pkg::REG_ESCAPE, 32'(mele_pkg::CHAR_CR));
    write_reg(mele_pkg::REG_COUNT, 32'd3);
    while (queued_count < 200) run_session();
    wait_idle();

    if (mismatches == 0) begin
      $display("modem_escape_and_line_editor test passed");
    end else begin
      $display("modem_escape_and_line_editor test failed");
    end
    $finish;
  end

endmodule
